// ===== src/spcd_pkg.sv =====
// Shared types and constants for the segment pair closest distance unit.
package spcd_pkg;

    localparam int PARAM_W    = 17;
    localparam int LIMIT_W    = 40;
    localparam int DIST_W     = 33;
    localparam int DIV_STAGES = 18;
    localparam int ROOT_W     = 33;
    localparam int SQ_W       = 2 * ROOT_W;

    typedef logic [PARAM_W-1:0] param_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [DIST_W-1:0]  dist_t;

    localparam param_t      PARAM_ONE   = 17'd65536;
    localparam limit_t      LIMIT_RESET = 40'd184467440737;
    localparam logic [63:0] NEAR_ZERO   = 64'd184467440738;

endpackage

// ===== src/spcd_div.sv =====
// Two-lane pipelined restoring divider giving rounded, clamped Q1.16 parameters.
module spcd_div #(
    parameter int NUM_W  = 74,
    parameter int SIDE_W = 1
) (
    input  logic                          aclk,
    input  logic [spcd_pkg::DIV_STAGES-1:0] stage_en,
    input  logic signed [NUM_W-1:0]       num [2],
    input  logic signed [NUM_W-1:0]       den [2],
    input  logic [SIDE_W-1:0]             side_in,
    output spcd_pkg::param_t              quo [2],
    output logic [SIDE_W-1:0]             side_out
);
    import spcd_pkg::*;

    localparam int RW = NUM_W + 19;

    logic [RW-1:0]         rem_reg  [DIV_STAGES][2];
    logic [RW-1:0]         dd_reg   [DIV_STAGES][2];
    logic [DIV_STAGES-1:0] q_reg    [DIV_STAGES][2];
    logic [SIDE_W-1:0]     side_reg [DIV_STAGES];

    logic [RW-1:0]         rem_next [DIV_STAGES][2];
    logic [RW-1:0]         dd_next  [DIV_STAGES][2];
    logic [DIV_STAGES-1:0] q_next   [DIV_STAGES][2];

    always_comb begin
        logic          ok;
        logic [RW-1:0] n_u;
        logic [RW-1:0] d_u;
        logic [RW-1:0] rem_in;
        logic [RW-1:0] dd_in;
        logic [RW-1:0] sh;
        logic [DIV_STAGES-1:0] q_in;
        for (int k = 0; k < DIV_STAGES; k++) begin
            for (int l = 0; l < 2; l++) begin
                if (k == 0) begin
                    // Negative, tiny or non-positive-denominator cases divide 0 by 1.
                    ok = !num[l][NUM_W-1] && ($unsigned(num[l]) >= NUM_W'(NEAR_ZERO))
                         && !den[l][NUM_W-1] && (den[l] != '0);
                    n_u = ok ? RW'($unsigned(num[l])) : '0;
                    d_u = ok ? RW'($unsigned(den[l])) : RW'(1);
                    rem_in = (n_u << 17) + d_u;
                    dd_in  = d_u << 1;
                    q_in   = '0;
                end else begin
                    rem_in = rem_reg[k-1][l];
                    dd_in  = dd_reg[k-1][l];
                    q_in   = q_reg[k-1][l];
                end
                sh = dd_in << (DIV_STAGES - 1 - k);
                dd_next[k][l] = dd_in;
                if (sh <= rem_in) begin
                    rem_next[k][l] = rem_in - sh;
                    q_next[k][l]   = q_in | (DIV_STAGES'(1) << (DIV_STAGES - 1 - k));
                end else begin
                    rem_next[k][l] = rem_in;
                    q_next[k][l]   = q_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (stage_en[k]) begin
                for (int l = 0; l < 2; l++) begin
                    rem_reg[k][l] <= rem_next[k][l];
                    dd_reg[k][l]  <= dd_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                end
                side_reg[k] <= (k == 0) ? side_in : side_reg[k-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (q_reg[DIV_STAGES-1][l] > DIV_STAGES'(PARAM_ONE)) begin
                quo[l] = PARAM_ONE;
            end else begin
                quo[l] = q_reg[DIV_STAGES-1][l][PARAM_W-1:0];
            end
        end
    end

    assign side_out = side_reg[DIV_STAGES-1];

endmodule

// ===== src/spcd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module spcd_sqrt #(
    parameter int SIDE_W = 34
) (
    input  logic                        aclk,
    input  logic [spcd_pkg::ROOT_W-1:0] stage_en,
    input  logic [spcd_pkg::SQ_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]           side_in,
    output logic [spcd_pkg::ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]           side_out
);
    import spcd_pkg::*;

    localparam int RMW = ROOT_W + 3;

    logic [RMW-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SQ_W-1:0]   rad_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    logic [RMW-1:0]    rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [SQ_W-1:0]   rad_next  [ROOT_W];

    always_comb begin
        logic [RMW-1:0]    rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   rad_in;
        logic [RMW-1:0]    rem2;
        logic [RMW-1:0]    trial;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = radicand;
            end else begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                rad_in  = rad_reg[k-1];
            end
            // The remainder never exceeds twice the partial root.
            rem2  = {rem_in[RMW-3:0], rad_in[SQ_W-1:SQ_W-2]};
            trial = {1'b0, root_in, 2'b01};
            rad_next[k] = rad_in << 2;
            if (rem2 >= trial) begin
                rem_next[k]  = rem2 - trial;
                root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem2;
                root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (stage_en[k]) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
                side_reg[k] <= (k == 0) ? side_in : side_reg[k-1];
            end
        end
    end

    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

// ===== src/segment_pair_closest_distance_unit.sv =====
// Top level of the segment pair closest distance unit.
// Each input beat carries the endpoints of two 3D segments; each output beat gives their least
// distance (Q17.16) and the closest-point parameters on both segments (Q1.16). The unit takes
// one beat every cycle while the output is not stalled, and holds 61 pipeline stages: seven for
// the edge vectors, dot products, the split wide products, the determinant and the clamping,
// eighteen for the bit-per-stage parameter dividers, three for the closest points and the split
// squared distance, and thirty-three for the bit-per-stage square root.
// Empty stages close up under backpressure, so input beats keep flowing while results wait.
module segment_pair_closest_distance_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          parallel_limit_we,
    input  spcd_pkg::limit_t              parallel_limit_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_first_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_first_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_first_start_z,
    input  logic signed [COORD_WIDTH-1:0] s_first_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_first_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_first_end_z,
    input  logic signed [COORD_WIDTH-1:0] s_second_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_second_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_second_start_z,
    input  logic signed [COORD_WIDTH-1:0] s_second_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_second_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_second_end_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output spcd_pkg::dist_t               m_closest_distance,
    output spcd_pkg::param_t              m_param_first,
    output spcd_pkg::param_t              m_param_second
);
    import spcd_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DFW = CW + 1;
    localparam int DW  = 2 * DFW + 2;
    localparam int HW  = DW / 2;
    localparam int HXW = HW + 1;
    localparam int PPW = 2 * HXW;
    localparam int PRW = 2 * DW;
    localparam int NW  = 2 * DW + 2;
    localparam int PW  = CW + 21;
    localparam int PL  = PW / 2;
    localparam int QOW = PW - PL + 1;
    localparam int QPW = 2 * QOW;
    localparam int SW  = 2 * PW + 2;
    localparam int SXW = (SW > 99) ? SW : 99;
    localparam int UVW = 9 * DFW;

    localparam int ST_DIV = 7;
    localparam int ST_P   = ST_DIV + DIV_STAGES;
    localparam int ST_Q   = ST_P + 1;
    localparam int ST_S   = ST_Q + 1;
    localparam int ST_SQ  = ST_S + 1;
    localparam int NST    = ST_SQ + ROOT_W;

    limit_t            parallel_limit_reg;
    logic [NST-1:0]    vld_reg;
    logic [NST-1:0]    stage_en;

    logic signed [CW-1:0]  pt_reg [12];
    logic [8:0][DFW-1:0]   uvw1_reg, uvw2_reg, uvw3_reg, uvw4_reg, uvw5_reg, uvw6_reg;
    logic [8:0][DFW-1:0]   uvw1_next;
    logic signed [DW-1:0]  a2_reg, b2_reg, c2_reg, d2_reg, e2_reg;
    logic signed [DW-1:0]  a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;
    logic signed [DW-1:0]  a4_reg, b4_reg, c4_reg, d4_reg, e4_reg;
    logic signed [PPW-1:0] pp3_reg  [6][4];
    logic signed [PPW-1:0] pp3_next [6][4];
    logic signed [PRW-1:0] ac4_reg, bb4_reg, be4_reg, cd4_reg, ae4_reg, bd4_reg;
    logic signed [NW-1:0]  sn5_reg, sd5_reg, tn5_reg, td5_reg, aa5_reg, bb5_reg, dd5_reg;
    logic signed [NW-1:0]  sn5_next, sd5_next, tn5_next, td5_next;
    logic signed [NW-1:0]  sn6_reg, sd6_reg, tn6_reg, td6_reg;
    logic signed [NW-1:0]  sn6_next, sd6_next, tn6_next;
    logic signed [NW-1:0]  div_num [2];
    logic signed [NW-1:0]  div_den [2];
    param_t                div_quo [2];
    logic [UVW-1:0]        div_side;
    logic [8:0][DFW-1:0]   uvw_d;
    logic signed [PW-1:0]  p_reg [3];
    logic signed [PW-1:0]  p_next [3];
    logic signed [QPW-1:0] sq_pp_reg  [3][3];
    logic signed [QPW-1:0] sq_pp_next [3][3];
    param_t                sc25_reg, tc25_reg, sc26_reg, tc26_reg, sc27_reg, tc27_reg;
    logic [SQ_W-1:0]       rad_reg, rad_next;
    logic [ROOT_W-1:0]     root_out;
    logic [2*PARAM_W-1:0]  sq_side_out;

    function automatic logic signed [DW-1:0] dot3(
        input logic [DFW-1:0] p0, input logic [DFW-1:0] p1, input logic [DFW-1:0] p2,
        input logic [DFW-1:0] q0, input logic [DFW-1:0] q1, input logic [DFW-1:0] q2
    );
        return DW'($signed(p0)) * DW'($signed(q0)) + DW'($signed(p1)) * DW'($signed(q1))
             + DW'($signed(p2)) * DW'($signed(q2));
    endfunction

    // Reassembles a wide product from its four half-width partial products.
    function automatic logic signed [PRW-1:0] join_prod(
        input logic signed [PPW-1:0] hh, input logic signed [PPW-1:0] hl,
        input logic signed [PPW-1:0] lh, input logic signed [PPW-1:0] ll
    );
        return (PRW'(hh) <<< (2 * HW)) + ((PRW'(hl) + PRW'(lh)) <<< HW) + PRW'(ll);
    endfunction

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parallel_limit_reg <= LIMIT_RESET;
        end else if (parallel_limit_we) begin
            parallel_limit_reg <= parallel_limit_wdata;
        end
    end

    // A stage loads when it is empty or when the stage after it loads.
    always_comb begin
        stage_en[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (stage_en[i]) begin
                    vld_reg[i] <= (i == 0) ? s_valid : vld_reg[i-1];
                end
            end
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[NST-1];

    // Stage 1: edge and offset vectors, ordered u xyz, v xyz, w xyz.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            uvw1_next[k]   = DFW'(pt_reg[3+k]) - DFW'(pt_reg[k]);
            uvw1_next[3+k] = DFW'(pt_reg[9+k]) - DFW'(pt_reg[6+k]);
            uvw1_next[6+k] = DFW'(pt_reg[k]) - DFW'(pt_reg[6+k]);
        end
    end

    // Stage 3: each wide product is split into signed high and unsigned low halves.
    always_comb begin
        logic signed [DW-1:0]  mx [6];
        logic signed [DW-1:0]  my [6];
        logic signed [HXW-1:0] xh, xl, yh, yl;
        mx[0] = a2_reg; my[0] = c2_reg;
        mx[1] = b2_reg; my[1] = b2_reg;
        mx[2] = b2_reg; my[2] = e2_reg;
        mx[3] = c2_reg; my[3] = d2_reg;
        mx[4] = a2_reg; my[4] = e2_reg;
        mx[5] = b2_reg; my[5] = d2_reg;
        for (int j = 0; j < 6; j++) begin
            xh = HXW'($signed(mx[j][DW-1:HW]));
            xl = $signed(HXW'(mx[j][HW-1:0]));
            yh = HXW'($signed(my[j][DW-1:HW]));
            yl = $signed(HXW'(my[j][HW-1:0]));
            pp3_next[j][0] = PPW'(xh) * PPW'(yh);
            pp3_next[j][1] = PPW'(xh) * PPW'(yl);
            pp3_next[j][2] = PPW'(xl) * PPW'(yh);
            pp3_next[j][3] = PPW'(xl) * PPW'(yl);
        end
    end

    // Stage 5: determinant, parallel test and first clamp of s.
    always_comb begin
        logic signed [NW-1:0] det, s_raw, t_raw, big_b, big_c, big_e, one_c, lim_s;
        det   = NW'(ac4_reg) - NW'(bb4_reg);
        s_raw = NW'(be4_reg) - NW'(cd4_reg);
        t_raw = NW'(ae4_reg) - NW'(bd4_reg);
        big_b = NW'(b4_reg) <<< 32;
        big_c = NW'(c4_reg) <<< 32;
        big_e = NW'(e4_reg) <<< 32;
        one_c = NW'(1) <<< 64;
        lim_s = $signed(NW'(parallel_limit_reg));
        sd5_next = det;
        td5_next = det;
        if (det < lim_s) begin
            sn5_next = '0;
            sd5_next = one_c;
            tn5_next = big_e;
            td5_next = big_c;
        end else begin
            sn5_next = s_raw;
            tn5_next = t_raw;
            if (s_raw < 0) begin
                sn5_next = '0;
                tn5_next = big_e;
                td5_next = big_c;
            end else if (s_raw > det) begin
                sn5_next = det;
                tn5_next = big_e + big_b;
                td5_next = big_c;
            end
        end
    end

    // Stage 6: clamp t to the segment and refit s against that end.
    always_comb begin
        logic signed [NW-1:0] x;
        logic                 refit;
        sn6_next = sn5_reg;
        sd6_next = sd5_reg;
        tn6_next = tn5_reg;
        x        = '0;
        refit    = 1'b0;
        if (tn5_reg < 0) begin
            tn6_next = '0;
            x        = -dd5_reg;
            refit    = 1'b1;
        end else if (tn5_reg > td5_reg) begin
            tn6_next = td5_reg;
            x        = bb5_reg - dd5_reg;
            refit    = 1'b1;
        end
        if (refit) begin
            if (x < 0) begin
                sn6_next = '0;
            end else if (x > aa5_reg) begin
                sn6_next = sd5_reg;
            end else begin
                sn6_next = x;
                sd6_next = aa5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pt_reg[0]  <= s_first_start_x;
            pt_reg[1]  <= s_first_start_y;
            pt_reg[2]  <= s_first_start_z;
            pt_reg[3]  <= s_first_end_x;
            pt_reg[4]  <= s_first_end_y;
            pt_reg[5]  <= s_first_end_z;
            pt_reg[6]  <= s_second_start_x;
            pt_reg[7]  <= s_second_start_y;
            pt_reg[8]  <= s_second_start_z;
            pt_reg[9]  <= s_second_end_x;
            pt_reg[10] <= s_second_end_y;
            pt_reg[11] <= s_second_end_z;
        end
        if (stage_en[1]) begin
            uvw1_reg <= uvw1_next;
        end
        if (stage_en[2]) begin
            a2_reg   <= dot3(uvw1_reg[0], uvw1_reg[1], uvw1_reg[2],
                             uvw1_reg[0], uvw1_reg[1], uvw1_reg[2]);
            b2_reg   <= dot3(uvw1_reg[0], uvw1_reg[1], uvw1_reg[2],
                             uvw1_reg[3], uvw1_reg[4], uvw1_reg[5]);
            c2_reg   <= dot3(uvw1_reg[3], uvw1_reg[4], uvw1_reg[5],
                             uvw1_reg[3], uvw1_reg[4], uvw1_reg[5]);
            d2_reg   <= dot3(uvw1_reg[0], uvw1_reg[1], uvw1_reg[2],
                             uvw1_reg[6], uvw1_reg[7], uvw1_reg[8]);
            e2_reg   <= dot3(uvw1_reg[3], uvw1_reg[4], uvw1_reg[5],
                             uvw1_reg[6], uvw1_reg[7], uvw1_reg[8]);
            uvw2_reg <= uvw1_reg;
        end
        if (stage_en[3]) begin
            pp3_reg  <= pp3_next;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
            d3_reg   <= d2_reg;
            e3_reg   <= e2_reg;
            uvw3_reg <= uvw2_reg;
        end
        if (stage_en[4]) begin
            ac4_reg  <= join_prod(pp3_reg[0][0], pp3_reg[0][1], pp3_reg[0][2], pp3_reg[0][3]);
            bb4_reg  <= join_prod(pp3_reg[1][0], pp3_reg[1][1], pp3_reg[1][2], pp3_reg[1][3]);
            be4_reg  <= join_prod(pp3_reg[2][0], pp3_reg[2][1], pp3_reg[2][2], pp3_reg[2][3]);
            cd4_reg  <= join_prod(pp3_reg[3][0], pp3_reg[3][1], pp3_reg[3][2], pp3_reg[3][3]);
            ae4_reg  <= join_prod(pp3_reg[4][0], pp3_reg[4][1], pp3_reg[4][2], pp3_reg[4][3]);
            bd4_reg  <= join_prod(pp3_reg[5][0], pp3_reg[5][1], pp3_reg[5][2], pp3_reg[5][3]);
            a4_reg   <= a3_reg;
            b4_reg   <= b3_reg;
            c4_reg   <= c3_reg;
            d4_reg   <= d3_reg;
            e4_reg   <= e3_reg;
            uvw4_reg <= uvw3_reg;
        end
        if (stage_en[5]) begin
            sn5_reg  <= sn5_next;
            sd5_reg  <= sd5_next;
            tn5_reg  <= tn5_next;
            td5_reg  <= td5_next;
            aa5_reg  <= NW'(a4_reg) <<< 32;
            bb5_reg  <= NW'(b4_reg) <<< 32;
            dd5_reg  <= NW'(d4_reg) <<< 32;
            uvw5_reg <= uvw4_reg;
        end
        if (stage_en[6]) begin
            sn6_reg  <= sn6_next;
            sd6_reg  <= sd6_next;
            tn6_reg  <= tn6_next;
            td6_reg  <= td5_reg;
            uvw6_reg <= uvw5_reg;
        end
    end

    assign div_num[0] = sn6_reg;
    assign div_den[0] = sd6_reg;
    assign div_num[1] = tn6_reg;
    assign div_den[1] = td6_reg;

    spcd_div #(
        .NUM_W  (NW),
        .SIDE_W (UVW)
    ) u_div (
        .aclk     (aclk),
        .stage_en (stage_en[ST_P-1:ST_DIV]),
        .num      (div_num),
        .den      (div_den),
        .side_in  (uvw6_reg),
        .quo      (div_quo),
        .side_out (div_side)
    );

    assign uvw_d = div_side;

    // Difference between the two quantized closest points, in units of 2^-32.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p_next[k] = (PW'($signed(uvw_d[6+k])) <<< 16)
                      + $signed(PW'(div_quo[0])) * PW'($signed(uvw_d[k]))
                      - $signed(PW'(div_quo[1])) * PW'($signed(uvw_d[3+k]));
        end
    end

    // Each coordinate difference is squared from its high and low halves.
    always_comb begin
        logic signed [QOW-1:0] sq_hi, sq_lo;
        for (int k = 0; k < 3; k++) begin
            sq_hi = QOW'($signed(p_reg[k][PW-1:PL]));
            sq_lo = $signed(QOW'(p_reg[k][PL-1:0]));
            sq_pp_next[k][0] = QPW'(sq_hi) * QPW'(sq_hi);
            sq_pp_next[k][1] = QPW'(sq_hi) * QPW'(sq_lo);
            sq_pp_next[k][2] = QPW'(sq_lo) * QPW'(sq_lo);
        end
    end

    // Squared distance, then the part above 2^-32 that feeds the root, saturated.
    always_comb begin
        logic signed [SW-1:0] s_sum;
        logic [SXW-1:0]       s_ext;
        s_sum = '0;
        for (int k = 0; k < 3; k++) begin
            s_sum = s_sum + (SW'(sq_pp_reg[k][0]) <<< (2 * PL))
                  + (SW'(sq_pp_reg[k][1]) <<< (PL + 1)) + SW'(sq_pp_reg[k][2]);
        end
        s_ext = SXW'($unsigned(s_sum));
        if (s_ext >= (SXW'(1) << 98)) begin
            rad_next = '1;
        end else begin
            rad_next = s_ext[97:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_P]) begin
            p_reg    <= p_next;
            sc25_reg <= div_quo[0];
            tc25_reg <= div_quo[1];
        end
        if (stage_en[ST_Q]) begin
            sq_pp_reg <= sq_pp_next;
            sc26_reg  <= sc25_reg;
            tc26_reg  <= tc25_reg;
        end
        if (stage_en[ST_S]) begin
            rad_reg  <= rad_next;
            sc27_reg <= sc26_reg;
            tc27_reg <= tc26_reg;
        end
    end

    spcd_sqrt #(
        .SIDE_W (2 * PARAM_W)
    ) u_sqrt (
        .aclk     (aclk),
        .stage_en (stage_en[NST-1:ST_SQ]),
        .radicand (rad_reg),
        .side_in  ({sc27_reg, tc27_reg}),
        .root     (root_out),
        .side_out (sq_side_out)
    );

    assign m_closest_distance = DIST_W'(root_out);
    assign m_param_first      = sq_side_out[2*PARAM_W-1:PARAM_W];
    assign m_param_second     = sq_side_out[PARAM_W-1:0];

    a_param_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_param_first <= PARAM_ONE) && (m_param_second <= PARAM_ONE))
        else $error("closest-point parameter above one");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&vld_reg) && !m_ready) |-> !s_ready)
        else $error("input taken while every stage is full and output stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output beat valid right after reset");

    a_param_held: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_P] && !stage_en[ST_P] |=> $stable(sc25_reg) && $stable(tc25_reg))
        else $error("stalled stage lost its parameters");

endmodule
